// ===== hw/rtl/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types, codes and defaults of the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int NUM_PRIORITIES_DEF = 32;
  localparam int RING_DEPTH_DEF     = 8;
  localparam int TASK_COUNT_DEF     = 256;

  localparam int OP_W      = 2;
  localparam int TASK_W    = 8;
  localparam int REQ_W     = 5;
  localparam int STAT_W    = 2;
  localparam int TOP_OUT_W = 6;

  typedef enum logic [OP_W-1:0] {
    OP_INS_TAIL = 2'd0,
    OP_INS_HEAD = 2'd1,
    OP_POP      = 2'd2,
    OP_PEEK     = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic enc1;
    logic enc2;
    logic load;
  } prq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_enc;
  } prq_stat_t;

endpackage

// ===== hw/rtl/prq_ctrl.sv =====
// ----------------------------------------------------------------------------
// prq_ctrl
// Sequencer of the priority ready queue: input handshake, step order and
// output valid.
// ----------------------------------------------------------------------------
module prq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  output prq_pkg::prq_cmd_t   cmd,
  input  prq_pkg::prq_stat_t  stat
);
  import prq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_ENC1 = 5'b00100,
    S_ENC2 = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_tready     = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_enc ? S_ENC1 : S_DONE;
      end
      S_ENC1: begin
        cmd.enc1  = 1'b1;
        state_nxt = S_ENC2;
      end
      S_ENC2: begin
        cmd.enc2  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hw/rtl/prq_datapath.sv =====
// ----------------------------------------------------------------------------
// prq_datapath
// Ring pointers, task store, level bitmap, two-stage priority encoder and
// result register of the priority ready queue.
// ----------------------------------------------------------------------------
module prq_datapath #(
  parameter int NUM_PRIORITIES = prq_pkg::NUM_PRIORITIES_DEF,
  parameter int RING_DEPTH     = prq_pkg::RING_DEPTH_DEF,
  parameter int TASK_COUNT     = prq_pkg::TASK_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  prq_pkg::prq_cmd_t              cmd,
  output prq_pkg::prq_stat_t             stat,
  input  prq_pkg::op_t                   in_operation,
  input  logic [prq_pkg::TASK_W-1:0]     in_task_id,
  input  logic [prq_pkg::REQ_W-1:0]      in_priority_req,
  output logic [prq_pkg::TASK_W-1:0]     out_task,
  output logic                           out_found,
  output prq_pkg::status_t               out_status,
  output logic [prq_pkg::TOP_OUT_W-1:0]  out_top_level
);
  import prq_pkg::*;

  localparam int LVL_W  = $clog2(NUM_PRIORITIES);
  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int TOP_W  = $clog2(NUM_PRIORITIES + 1);
  localparam int DEPTH  = NUM_PRIORITIES * RING_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NGRP   = (NUM_PRIORITIES + 7) / 8;
  localparam int BMP_W  = NGRP * 8;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    ptr_prev = (p == '0) ? PTR_W'(RING_DEPTH - 1) : p - 1'b1;
  endfunction

  // captured item
  op_t               op_r;
  logic [TASK_W-1:0] task_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [6:0]        req_ext;

  // queue state
  logic [PTR_W-1:0]          head_r [NUM_PRIORITIES];
  logic [PTR_W-1:0]          tail_r [NUM_PRIORITIES];
  logic [NUM_PRIORITIES-1:0] bitmap_r;
  logic [TOP_W-1:0]          top_r;
  logic [TASK_W-1:0]         mem [DEPTH];
  logic [TASK_W-1:0]         rd_data_r;

  // step results
  logic    found_r;
  status_t status_r;

  // encoder stage
  logic       grp_any_r [NGRP];
  logic [2:0] grp_idx_r [NGRP];
  logic [BMP_W-1:0] bm_pad;
  logic [TOP_W-1:0] enc_top;

  // output register
  logic [TASK_W-1:0]    out_task_r;
  logic                 out_found_r;
  status_t              out_status_r;
  logic [TOP_OUT_W-1:0] out_top_r;
  logic [TOP_W+TOP_OUT_W-1:0] top_ext;

  // execute step
  logic             is_ins, is_tail, task_bad, full, ins_ok;
  logic             top_empty, q_empty, rd_ok, drains, top_raise;
  logic [LVL_W-1:0] top_idx, sel;
  logic [PTR_W-1:0] h, t, h_next, h_prev, acc_ptr;
  logic [ADDR_W-1:0] addr;
  status_t          status_nxt;

  assign req_ext = {2'b00, in_priority_req};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_operation;
      task_r <= in_task_id;
      if (req_ext >= 7'(NUM_PRIORITIES)) begin
        lvl_r <= LVL_W'(NUM_PRIORITIES - 1);
      end else begin
        lvl_r <= req_ext[LVL_W-1:0];
      end
    end
  end

  always_comb begin
    is_ins    = (op_r == OP_INS_TAIL) || (op_r == OP_INS_HEAD);
    is_tail   = (op_r == OP_INS_TAIL);
    top_idx   = top_r[LVL_W-1:0];
    top_empty = (top_r >= TOP_W'(NUM_PRIORITIES));
    sel       = is_ins ? lvl_r : top_idx;
    h         = head_r[sel];
    t         = tail_r[sel];
    h_next    = ptr_next(h);
    h_prev    = ptr_prev(h);
    task_bad  = ({1'b0, task_r} >= 9'(TASK_COUNT));
    full      = is_tail ? (ptr_next(t) == h) : (h_prev == t);
    ins_ok    = is_ins && !task_bad && !full;
    q_empty   = top_empty || (h == t);
    rd_ok     = !is_ins && !q_empty;
    drains    = (op_r == OP_POP) && rd_ok && (h_next == t);
    // a new task above the current top becomes the top directly
    top_raise = ins_ok && (top_empty || (lvl_r > top_idx));
    acc_ptr   = is_ins ? (is_tail ? t : h_prev) : h;
    addr      = ADDR_W'(sel) * ADDR_W'(RING_DEPTH) + ADDR_W'(acc_ptr);
    if (is_ins) begin
      status_nxt = ins_ok ? ST_OK : ST_FULL;
    end else begin
      status_nxt = q_empty ? ST_EMPTY : ST_OK;
    end
  end

  assign stat.need_enc = drains;

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (ins_ok) begin
        mem[addr] <= task_r;
      end
      rd_data_r <= mem[addr];
      found_r   <= rd_ok;
      status_r  <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PRIORITIES; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
      bitmap_r <= '0;
    end else if (cmd.exec) begin
      if (ins_ok) begin
        bitmap_r[sel] <= 1'b1;
        if (is_tail) begin
          tail_r[sel] <= ptr_next(t);
        end else begin
          head_r[sel] <= h_prev;
        end
      end
      if (rd_ok && (op_r == OP_POP)) begin
        head_r[sel] <= h_next;
      end
      if (drains) begin
        bitmap_r[sel] <= 1'b0;
      end
    end
  end

  // encoder, first stage: highest set bit within each group of eight levels
  assign bm_pad = BMP_W'(bitmap_r);

  always_ff @(posedge clk) begin
    if (cmd.enc1) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_any_r[g] <= 1'b0;
        grp_idx_r[g] <= 3'd0;
        for (int i = 0; i < 8; i++) begin
          if (bm_pad[g*8+i]) begin
            grp_any_r[g] <= 1'b1;
            grp_idx_r[g] <= 3'(i);
          end
        end
      end
    end
  end

  // encoder, second stage: highest non-empty group
  always_comb begin
    enc_top = TOP_W'(NUM_PRIORITIES);
    for (int g = 0; g < NGRP; g++) begin
      if (grp_any_r[g]) begin
        enc_top = TOP_W'(g * 8) | TOP_W'(grp_idx_r[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= TOP_W'(NUM_PRIORITIES);
    end else if (cmd.exec && top_raise) begin
      top_r <= TOP_W'(lvl_r);
    end else if (cmd.enc2) begin
      top_r <= enc_top;
    end
  end

  assign top_ext = {{TOP_OUT_W{1'b0}}, top_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_task_r   <= found_r ? rd_data_r : '0;
      out_found_r  <= found_r;
      out_status_r <= status_r;
      out_top_r    <= top_ext[TOP_OUT_W-1:0];
    end
  end

  assign out_task      = out_task_r;
  assign out_found     = out_found_r;
  assign out_status    = out_status_r;
  assign out_top_level = out_top_r;

endmodule

// ===== hw/rtl/priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue
// Task ready queue: one ring per priority level, a bitmap of busy levels and
// a top-priority register.
// ----------------------------------------------------------------------------
// Usage:
//   Input item: in_tuser carries the operation (insert tail, insert head,
//   pop top, peek top); in_tdata carries task_id and priority_req. Every
//   item returns exactly one result item on the out_ channel with the task
//   found, a found flag, a status code and the top level after the step.
//   The block works on one item at a time and takes a new item only after
//   the last one has loaded its result. Each item is captured, executed and
//   its result loaded; a pop that empties a level adds the two registered
//   stages of the priority encoder that finds the next lower level.
//   Reset clears all ring pointers and the level bitmap at once and sets the
//   top level to empty; the task store is not cleared.
//   When the receiver stalls, the result holds in the output register; the
//   next item is still accepted and waits in its last step until the output
//   register is free.
// ----------------------------------------------------------------------------
module priority_ready_queue #(
  parameter int NUM_PRIORITIES = prq_pkg::NUM_PRIORITIES_DEF,
  parameter int RING_DEPTH     = prq_pkg::RING_DEPTH_DEF,
  parameter int TASK_COUNT     = prq_pkg::TASK_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] task_id, [12:8] priority_req, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] out_task, [8] found, [10:9] status,
                                  // [16:11] top_level, rest zero
);
  import prq_pkg::*;

  prq_cmd_t  cmd;
  prq_stat_t stat;

  logic [TASK_W-1:0]    res_task;
  logic                 res_found;
  status_t              res_status;
  logic [TOP_OUT_W-1:0] res_top;

  prq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  prq_datapath #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .RING_DEPTH     (RING_DEPTH),
    .TASK_COUNT     (TASK_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_operation    (op_t'(in_tuser)),
    .in_task_id      (in_tdata[7:0]),
    .in_priority_req (in_tdata[12:8]),
    .out_task        (res_task),
    .out_found       (res_found),
    .out_status      (res_status),
    .out_top_level   (res_top)
  );

  assign out_tdata = {7'd0, res_top, res_status, res_found, res_task};

  // one item in flight: no second item right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // a result only appears from the final step, never while idle
  a_result_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised without a step in progress");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority ready queue. A short directed table
// covers reset, the task and level extremes, full levels and level-emptying
// pops. A long random run follows, with insert-heavy and pop-heavy stretches.
// Every accepted item is run through a local model of the rings, the bitmap
// and the top level. Each result item is compared field by field, in order,
// with the expected results.
// ----------------------------------------------------------------------------
module tb_top;
  import prq_pkg::*;

  localparam int LEVELS      = NUM_PRIORITIES_DEF;
  localparam int RAND_ITEMS  = 1100;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 12;

  typedef struct packed {
    logic [TASK_W-1:0]    task_out;
    logic                 found;
    status_t              status;
    logic [TOP_OUT_W-1:0] top_level;
  } prq_result_t;

  typedef struct packed {
    op_t              op;
    logic [TASK_W-1:0] tid;
    logic [REQ_W-1:0]  prio;
    logic              typed;
    prq_result_t       want;
  } stim_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [7:0] task_id, [12:8] priority_req, rest zero
  logic [1:0]  in_tuser   = '0;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [7:0] out_task, [8] found, [10:9] status,
                                  // [16:11] top_level, rest zero

  // model state
  logic [LEVELS-1:0]    lvl_bitmap;
  logic [TOP_OUT_W-1:0] top_lvl;
  logic [2:0]           lvl_head [LEVELS];
  logic [2:0]           lvl_tail [LEVELS];
  logic [TASK_W-1:0]    task_slots [LEVELS*RING_DEPTH_DEF];

  prq_result_t pending_results [$];
  prq_result_t want;
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  int          send_idle_pct  = 6;
  int          recv_idle_pct  = 68;

  localparam prq_result_t NO_RESULT = '0;

  stim_row_t directed_rows [24] = '{
    '{OP_POP,      8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, ST_EMPTY, 6'd32}},
    '{OP_PEEK,     8'h5A, 5'd31, 1'b1, '{8'h00, 1'b0, ST_EMPTY, 6'd32}},
    '{OP_INS_TAIL, 8'hFF, 5'd31, 1'b1, '{8'h00, 1'b0, ST_OK,    6'd31}},
    '{OP_PEEK,     8'h00, 5'd0,  1'b1, '{8'hFF, 1'b1, ST_OK,    6'd31}},
    '{OP_POP,      8'h00, 5'd0,  1'b1, '{8'hFF, 1'b1, ST_OK,    6'd32}},
    '{OP_INS_TAIL, 8'h00, 5'd0,  1'b1, '{8'h00, 1'b0, ST_OK,    6'd0}},
    '{OP_INS_HEAD, 8'h81, 5'd0,  1'b1, '{8'h00, 1'b0, ST_OK,    6'd0}},
    '{OP_PEEK,     8'h00, 5'd0,  1'b1, '{8'h81, 1'b1, ST_OK,    6'd0}},
    '{OP_INS_TAIL, 8'h11, 5'd17, 1'b1, '{8'h00, 1'b0, ST_OK,    6'd17}},
    '{OP_INS_TAIL, 8'h12, 5'd17, 1'b1, '{8'h00, 1'b0, ST_OK,    6'd17}},
    '{OP_INS_TAIL, 8'h13, 5'd17, 1'b1, '{8'h00, 1'b0, ST_OK,    6'd17}},
    '{OP_INS_TAIL, 8'h14, 5'd17, 1'b1, '{8'h00, 1'b0, ST_OK,    6'd17}},
    '{OP_INS_TAIL, 8'h15, 5'd17, 1'b1, '{8'h00, 1'b0, ST_OK,    6'd17}},
    '{OP_INS_TAIL, 8'h16, 5'd17, 1'b1, '{8'h00, 1'b0, ST_OK,    6'd17}},
    '{OP_INS_TAIL, 8'h17, 5'd17, 1'b1, '{8'h00, 1'b0, ST_OK,    6'd17}},
    // level 17 now holds seven tasks: both inserts are refused
    '{OP_INS_TAIL, 8'h18, 5'd17, 1'b1, '{8'h00, 1'b0, ST_FULL,  6'd17}},
    '{OP_INS_HEAD, 8'h19, 5'd17, 1'b1, '{8'h00, 1'b0, ST_FULL,  6'd17}},
    '{OP_POP,      8'h00, 5'd0,  1'b1, '{8'h11, 1'b1, ST_OK,    6'd17}},
    '{OP_INS_HEAD, 8'h20, 5'd17, 1'b0, NO_RESULT},
    '{OP_POP,      8'hC3, 5'd9,  1'b0, NO_RESULT},
    '{OP_INS_TAIL, 8'h3C, 5'd31, 1'b1, '{8'h00, 1'b0, ST_OK,    6'd31}},
    // emptying level 31 falls back to level 17
    '{OP_POP,      8'h00, 5'd0,  1'b1, '{8'h3C, 1'b1, ST_OK,    6'd17}},
    '{OP_INS_HEAD, 8'h00, 5'd30, 1'b0, NO_RESULT},
    '{OP_PEEK,     8'hE7, 5'd2,  1'b0, NO_RESULT}
  };

  priority_ready_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  function automatic logic [TOP_OUT_W-1:0] highest_busy_level();
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (lvl_bitmap[l]) return TOP_OUT_W'(l);
    end
    return TOP_OUT_W'(LEVELS);
  endfunction

  function automatic prq_result_t next_queue_result(op_t op, logic [TASK_W-1:0] tid,
                                                    logic [REQ_W-1:0] lvl);
    prq_result_t r;
    logic [2:0]  ptr;
    logic [4:0]  top;
    r = NO_RESULT;
    r.status = ST_OK;
    case (op)
      OP_INS_TAIL: begin
        ptr = lvl_tail[lvl] + 3'd1;
        if (ptr == lvl_head[lvl]) begin
          r.status = ST_FULL;
        end else begin
          task_slots[{lvl, lvl_tail[lvl]}] = tid;
          lvl_tail[lvl] = ptr;
          lvl_bitmap[lvl] = 1'b1;
        end
        top_lvl = highest_busy_level();
      end
      OP_INS_HEAD: begin
        ptr = lvl_head[lvl] - 3'd1;
        if (ptr == lvl_tail[lvl]) begin
          r.status = ST_FULL;
        end else begin
          lvl_head[lvl] = ptr;
          task_slots[{lvl, ptr}] = tid;
          lvl_bitmap[lvl] = 1'b1;
        end
        top_lvl = highest_busy_level();
      end
      default: begin
        top = top_lvl[4:0];
        if (top_lvl >= TOP_OUT_W'(LEVELS) || lvl_head[top] == lvl_tail[top]) begin
          r.status = ST_EMPTY;
        end else begin
          r.task_out = task_slots[{top, lvl_head[top]}];
          r.found = 1'b1;
          if (op == OP_POP) begin
            lvl_head[top] = lvl_head[top] + 3'd1;
            // drop the level bit once its ring runs dry
            if (lvl_head[top] == lvl_tail[top]) begin
              lvl_bitmap[top] = 1'b0;
              top_lvl = highest_busy_level();
            end
          end
        end
      end
    endcase
    r.top_level = top_lvl;
    return r;
  endfunction

  task automatic offer_item(op_t op, logic [TASK_W-1:0] tid, logic [REQ_W-1:0] prio,
                            logic typed, prq_result_t typed_want);
    prq_result_t r;
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, prio, tid};
    in_tuser  <= op;
    // look at tready mid-cycle, then step to the accepting edge
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    r = next_queue_result(op, tid, prio);
    pending_results.push_back(typed ? typed_want : r);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    op_t              op;
    logic [TASK_W-1:0] tid;
    logic [REQ_W-1:0]  prio;
    int               ins_pct;
    lvl_bitmap = '0;
    top_lvl    = TOP_OUT_W'(LEVELS);
    for (int l = 0; l < LEVELS; l++) begin
      lvl_head[l] = '0;
      lvl_tail[l] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].op, directed_rows[i].tid, directed_rows[i].prio,
                 directed_rows[i].typed, directed_rows[i].want);
    end

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3 || i == 2 * RAND_ITEMS / 3) begin
        // hold the sender until the queue has answered everything
        in_tvalid <= 1'b0;
        drain_results();
        send_idle_pct = (i == RAND_ITEMS / 3) ? 68 : 0;
        recv_idle_pct = (i == RAND_ITEMS / 3) ? 6 : 0;
      end
      // alternate fill-heavy, drain-heavy and balanced stretches
      case ((i / 90) % 3)
        0:       ins_pct = 75;
        1:       ins_pct = 25;
        default: ins_pct = 50;
      endcase
      if ($urandom_range(99) < ins_pct) begin
        op = $urandom_range(1) ? OP_INS_TAIL : OP_INS_HEAD;
      end else begin
        op = ($urandom_range(3) != 0) ? OP_POP : OP_PEEK;
      end
      // crowd a few levels so rings fill up and empty out
      if ($urandom_range(1)) begin
        prio = REQ_W'(($urandom_range(1) ? 28 : 0) + $urandom_range(3));
      end else begin
        prio = REQ_W'($urandom_range(31));
      end
      tid = TASK_W'($urandom_range(255));
      offer_item(op, tid, prio, 1'b0, NO_RESULT);
    end
    in_tvalid <= 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("priority_ready_queue: match");
    end else begin
      $display("priority_ready_queue: mismatch");
    end
    $finish;
  end

  // check mid-cycle: valid and ready here mean an accept at the next edge
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: %h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[7:0] !== want.task_out) begin
          $error("out_task: expected %0d, got %0d", want.task_out, out_tdata[7:0]);
          mismatch_count++;
        end
        if (out_tdata[8] !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_tdata[8]);
          mismatch_count++;
        end
        if (out_tdata[10:9] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[10:9]);
          mismatch_count++;
        end
        if (out_tdata[16:11] !== want.top_level) begin
          $error("top_level: expected %0d, got %0d", want.top_level, out_tdata[16:11]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("priority_ready_queue: mismatch");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/prq_pkg.sv
hw/rtl/prq_ctrl.sv
hw/rtl/prq_datapath.sv
hw/rtl/priority_ready_queue.sv
test/tb_top.sv
